// ===== hdl/rfm_pkg.sv =====
// Shared constants for the reciprocal frequency meter.
package rfm_pkg;

   localparam int TIMER_BITS_DEFAULT = 16;
   localparam int CAPTURE_BITS = 16;
   localparam int FREQ_BITS = 16;
   localparam int NUM_BITS = 32;
   localparam int FRAC_BITS = 8;
   localparam int DIVIDEND_BITS = NUM_BITS - FRAC_BITS;
   localparam logic [NUM_BITS-1:0] NUMERATOR_RESET = 32'd281604700;
   localparam logic [DIVIDEND_BITS-1:0] FREQ_LIMIT = 24'd65535;

endpackage

// ===== hdl/reciprocal_frequency_meter_top.sv =====
// Reciprocal frequency meter: pairs rising-edge captures and divides the numerator by the period.
// The closing edge of a pair yields a result on rsp_tvalid once the divider is done, unless the
// period is zero or the quotient reaches FREQ_LIMIT. The 24-step restoring divider, one quotient
// bit per cycle, holds the block busy; other requests are taken every cycle while it is idle.
// A waiting result does not block the next request; only the divider's hand-over waits for it.
// Reset (synchronous): no held edge, numerator back to its reset value, output empty.
module reciprocal_frequency_meter_top
   import rfm_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CAPTURE_BITS-1:0] req_tdata,  // [15:0] capture_value
   input  logic                  req_tuser,    // [0] pin_high
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [FREQ_BITS-1:0]  rsp_tdata,    // [15:0] frequency
   input  logic                  csr_wr_en,
   input  logic [NUM_BITS-1:0]   csr_wr_data
);

   localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     pend_ff, pend_in;
   logic [TIMER_BITS-1:0]    first_ff, first_in;
   logic [TIMER_BITS-1:0]    per_ff, per_in;
   logic [TIMER_BITS-1:0]    rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] div_ff, div_in;
   logic [DIVIDEND_BITS-1:0] quot_ff, quot_in;
   logic [NUM_BITS-1:0]      num_ff, num_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FREQ_BITS-1:0]     rsp_data_ff, rsp_data_in;

   logic [TIMER_BITS+CAPTURE_BITS-1:0] cap_wide;
   logic [TIMER_BITS-1:0]    cap;
   logic [TIMER_BITS-1:0]    period_now;
   logic [TIMER_BITS:0]      rem_shift;
   logic [TIMER_BITS:0]      diff;
   logic                     ge;
   logic                     accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign cap_wide   = {{TIMER_BITS{1'b0}}, req_tdata};
   assign cap        = cap_wide[TIMER_BITS-1:0];
   assign period_now = cap - first_ff;
   assign rem_shift  = {rem_ff, div_ff[DIVIDEND_BITS-1]};
   assign diff       = rem_shift - {1'b0, per_ff};
   assign ge         = (rem_shift >= {1'b0, per_ff});
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      first_in     = first_ff;
      per_in       = per_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quot_in      = quot_ff;
      num_in       = csr_wr_en ? csr_wr_data : num_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser) begin
               if (!pend_ff) begin
                  first_in = cap;
                  pend_in  = 1'b1;
               end else begin
                  pend_in = 1'b0;
                  if (period_now != '0) begin
                     per_in   = period_now;
                     div_in   = num_ff[NUM_BITS-1:FRAC_BITS];
                     rem_in   = '0;
                     quot_in  = '0;
                     cnt_in   = '0;
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            div_in  = {div_ff[DIVIDEND_BITS-2:0], 1'b0};
            rem_in  = ge ? diff[TIMER_BITS-1:0] : rem_shift[TIMER_BITS-1:0];
            quot_in = {quot_ff[DIVIDEND_BITS-2:0], ge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIVIDEND_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (quot_ff < FREQ_LIMIT) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = quot_ff[FREQ_BITS-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         first_ff     <= '0;
         num_ff       <= NUMERATOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         num_ff       <= num_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      per_ff      <= per_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quot_ff     <= quot_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hdl/rfm_checker.sv =====
// Port-level checks for the reciprocal frequency meter, bound to the top level.
module rfm_checker
   import rfm_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    req_tuser,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [FREQ_BITS-1:0]    rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response present after reset");

   a_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != 16'hFFFF)
      else $error("frequency at or above limit");

   a_pin_low_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> req_tready)
      else $error("ignored request made the block busy");

endmodule

bind reciprocal_frequency_meter_top rfm_checker u_rfm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
